>>> rtl/fid_pkg.sv
package fid_pkg;

	localparam int IDX_W   = 7;
	localparam int VAL_W   = 64;
	localparam int TRI_W   = 2 * IDX_W;
	localparam int HALF_W  = 32;
	localparam int PROD_W  = 128;
	localparam int SC_W    = 131;
	localparam int WGT_W   = 4;
	localparam int IN_W    = 4 * IDX_W + VAL_W;
	localparam int TDATA_W = 96;
	localparam int TUSER_W = 2;

	localparam logic [2:0] MUL_LAST = 3'd4;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_DIGEST = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_ORDER,
		ST_PLAN,
		ST_DRD,
		ST_MAG,
		ST_MUL,
		ST_SCALE,
		ST_ROUND,
		ST_WRITE,
		ST_GOUT
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       exec;
		logic       order;
		logic       plan;
		logic       d_rd;
		logic       mag;
		logic       mul;
		logic [2:0] mul_cnt;
		logic       scale;
		logic       round;
		logic       wr;
		logic       out_load;
		logic       init_wr;
		logic [2:0] acc_idx;
	} cmd_t;

	typedef struct packed {
		op_t        op;
		logic       idx_ok;
		logic       v_zero;
		logic [1:0] npairs;
		logic       clr_last;
		logic       out_busy;
	} status_t;

	// packed lower-triangle address of (a,b)
	function automatic logic [TRI_W-1:0] tri_addr(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W-1:0] hi;
		logic [IDX_W-1:0] lo;
		logic [IDX_W:0]   hi1;
		logic [TRI_W:0]   prod;
		hi   = (a > b) ? a : b;
		lo   = (a > b) ? b : a;
		hi1  = {1'b0, hi} + 1'b1;
		prod = (TRI_W + 1)'(hi) * (TRI_W + 1)'(hi1);
		return prod[TRI_W:1] + TRI_W'(lo);
	endfunction

	// same triangle entry, i.e. equal as unordered pairs
	function automatic logic pair_eq(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
			input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] d);
		return ((a == c) && (b == d)) || ((a == d) && (b == c));
	endfunction

endpackage

>>> rtl/fid_ctrl.sv
module fid_ctrl import fid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t     state_q, state_d;
	logic [2:0] acc_q, acc_d;
	logic [2:0] mul_q, mul_d;
	logic [2:0] acc_last;

	assign acc_last = {st.npairs, 1'b0} - 3'd1;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			acc_q   <= '0;
			mul_q   <= '0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			mul_q   <= mul_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		acc_d       = acc_q;
		mul_d       = mul_q;
		cmd         = '0;
		cmd.acc_idx = acc_q;
		cmd.mul_cnt = mul_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (st.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				unique case (st.op)
					OP_LOAD, OP_CLEAR: state_d = ST_IDLE;
					OP_READ:           state_d = ST_GOUT;
					OP_DIGEST:         state_d = (st.idx_ok && !st.v_zero) ? ST_ORDER : ST_IDLE;
					default:           state_d = ST_IDLE;
				endcase
			end
			ST_ORDER: begin
				cmd.order = 1'b1;
				state_d   = ST_PLAN;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				acc_d    = '0;
				state_d  = ST_DRD;
			end
			ST_DRD: begin
				cmd.d_rd = 1'b1;
				state_d  = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag = 1'b1;
				mul_d   = '0;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				mul_d   = mul_q + 3'd1;
				if (mul_q == MUL_LAST)
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr = 1'b1;
				if (acc_q == acc_last) begin
					state_d = ST_IDLE;
				end else begin
					acc_d   = acc_q + 3'd1;
					state_d = ST_DRD;
				end
			end
			ST_GOUT: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/fid_dp.sv
module fid_dp import fid_pkg::*; #(
	parameter int BASIS_FUNCTIONS = 128,
	parameter int FRACTION_BITS   = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          st,
	input  logic [IN_W-1:0]  in_data,
	input  logic [TUSER_W-1:0] in_op,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] out_data
);

	localparam int EFF_N     = (BASIS_FUNCTIONS < (1 << IDX_W)) ? BASIS_FUNCTIONS : (1 << IDX_W);
	localparam int TRI_DEPTH = EFF_N * (EFF_N + 1) / 2;
	localparam int ADDR_W    = $clog2(TRI_DEPTH);
	localparam int RSH       = FRACTION_BITS + 3;
	localparam logic [IDX_W:0]     IDX_LIM = (IDX_W + 1)'(EFF_N);
	localparam logic [ADDR_W-1:0]  CLR_END = ADDR_W'(TRI_DEPTH - 1);
	localparam logic [SC_W-1:0]    RND     = SC_W'(1) << (RSH - 1);

	logic [VAL_W-1:0] g_mem [TRI_DEPTH];
	logic [VAL_W-1:0] d_mem [TRI_DEPTH];

	op_t              op_q;
	logic [IDX_W-1:0] p_q, q_q, r_q, s_q;
	logic [VAL_W-1:0] v_q;
	logic [IDX_W-1:0] i_q, j_q, k_q, l_q;
	logic [VAL_W-1:0] vmag_q, dmag_q;
	logic [ADDR_W-1:0] ab_q [3];
	logic [ADDR_W-1:0] cd_q [3];
	logic [WGT_W-1:0]  w_q [3];
	logic [1:0]        npairs_q;
	logic [ADDR_W-1:0] clr_q;
	logic              flip_q;
	logic [2*HALF_W-1:0] part_s1;
	logic [1:0]        sh_s1;
	logic [PROD_W-1:0] acc_q;
	logic [SC_W-1:0]   sc_q;
	logic [VAL_W-1:0]  rt_q;
	logic [VAL_W-1:0]  d_rd_q, g_rd_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  out_data_q;

	logic              p_ok, q_ok, r_ok, s_ok, idx_ok;
	logic [TRI_W-1:0]  pq_tri;
	logic [ADDR_W-1:0] pq_addr, ga, da;
	logic [ADDR_W-1:0] sel_ab, sel_cd;
	logic [WGT_W-1:0]  sel_w;
	logic              sub;

	// ordering
	logic [IDX_W-1:0] p1, q1, r1, s1;
	logic             pq_ge;

	// plan
	logic             half, case_a, case_b, single;
	logic [IDX_W-1:0] x_a, x_b, x_c, x_d;
	logic [WGT_W-1:0] w0, w1, w2;

	logic [PROD_W-1:0] part_sh;
	logic [HALF_W-1:0] mul_a, mul_b;
	logic [SC_W-1:0]   prod_ext, sc_d, rnd_sum;
	logic [VAL_W-1:0]  g_sum, rt_add;

	logic              g_we, g_re;
	logic [ADDR_W-1:0] g_wa, g_ra;
	logic [VAL_W-1:0]  g_wd;
	logic              d_we;

	// capture of the accepted item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op_t'(in_op);
			p_q  <= in_data[0 +: IDX_W];
			q_q  <= in_data[IDX_W +: IDX_W];
			r_q  <= in_data[2*IDX_W +: IDX_W];
			s_q  <= in_data[3*IDX_W +: IDX_W];
			v_q  <= in_data[4*IDX_W +: VAL_W];
		end
	end

	assign p_ok   = {1'b0, p_q} < IDX_LIM;
	assign q_ok   = {1'b0, q_q} < IDX_LIM;
	assign r_ok   = {1'b0, r_q} < IDX_LIM;
	assign s_ok   = {1'b0, s_q} < IDX_LIM;
	assign idx_ok = p_ok && q_ok && ((op_q != OP_DIGEST) || (r_ok && s_ok));
	assign pq_tri = tri_addr(p_q, q_q);
	assign pq_addr = pq_tri[ADDR_W-1:0];

	assign p1    = (p_q > q_q) ? p_q : q_q;
	assign q1    = (p_q > q_q) ? q_q : p_q;
	assign r1    = (r_q > s_q) ? r_q : s_q;
	assign s1    = (r_q > s_q) ? s_q : r_q;
	assign pq_ge = (p1 > r1) || ((p1 == r1) && (q1 >= s1));

	always_ff @(posedge clk) begin
		if (cmd.order) begin
			i_q    <= pq_ge ? p1 : r1;
			j_q    <= pq_ge ? q1 : s1;
			k_q    <= pq_ge ? r1 : p1;
			l_q    <= pq_ge ? s1 : q1;
			vmag_q <= v_q[VAL_W-1] ? (VAL_W'(0) - v_q) : v_q;
		end
	end

	// coincidence cases pick the pair list and weights (in eighths)
	always_comb begin
		half   = pair_eq(i_q, j_q, k_q, l_q);
		case_a = (j_q == k_q);
		case_b = !case_a && ((i_q == k_q) || (j_q == l_q));
		single = case_a && ((i_q == j_q) || (k_q == l_q));
		x_a = i_q;
		x_b = case_a ? l_q : k_q;
		x_c = case_a ? k_q : j_q;
		x_d = case_a ? j_q : l_q;
		if (case_a || case_b) begin
			w0 = half ? 4'd3 : 4'd6;
			w1 = pair_eq(x_a, x_b, x_c, x_d) ? 4'd2 : 4'd4;
		end else begin
			w0 = half ? 4'd4 : 4'd8;
			w1 = pair_eq(i_q, k_q, j_q, l_q) ? 4'd1 : 4'd2;
		end
		if (single)
			w0 = half ? 4'd2 : 4'd4;
		w2 = w1;
	end

	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			ab_q[0] <= ADDR_W'(tri_addr(i_q, j_q));
			cd_q[0] <= ADDR_W'(tri_addr(k_q, l_q));
			ab_q[1] <= ADDR_W'(tri_addr(x_a, x_b));
			cd_q[1] <= ADDR_W'(tri_addr(x_c, x_d));
			ab_q[2] <= ADDR_W'(tri_addr(i_q, l_q));
			cd_q[2] <= ADDR_W'(tri_addr(k_q, j_q));
			w_q[0]  <= w0;
			w_q[1]  <= w1;
			w_q[2]  <= w2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			npairs_q <= 2'd1;
		else if (cmd.plan)
			npairs_q <= single ? 2'd1 :
				((case_a || case_b || (i_q == j_q) || (k_q == l_q)) ? 2'd2 : 2'd3);
	end

	always_comb begin
		case (cmd.acc_idx[2:1])
			2'd0: begin sel_ab = ab_q[0]; sel_cd = cd_q[0]; sel_w = w_q[0]; end
			2'd1: begin sel_ab = ab_q[1]; sel_cd = cd_q[1]; sel_w = w_q[1]; end
			default: begin sel_ab = ab_q[2]; sel_cd = cd_q[2]; sel_w = w_q[2]; end
		endcase
		ga  = cmd.acc_idx[0] ? sel_cd : sel_ab;
		da  = cmd.acc_idx[0] ? sel_ab : sel_cd;
		sub = (cmd.acc_idx[2:1] != 2'd0);
	end

	// product of magnitudes, one 32x32 partial per cycle
	assign mul_a = cmd.mul_cnt[1] ? vmag_q[HALF_W +: HALF_W] : vmag_q[0 +: HALF_W];
	assign mul_b = cmd.mul_cnt[0] ? dmag_q[HALF_W +: HALF_W] : dmag_q[0 +: HALF_W];

	always_comb begin
		case (sh_s1)
			2'd0:    part_sh = PROD_W'(part_s1);
			2'd3:    part_sh = PROD_W'(part_s1) << (2 * HALF_W);
			default: part_sh = PROD_W'(part_s1) << HALF_W;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mag) begin
			dmag_q <= d_rd_q[VAL_W-1] ? (VAL_W'(0) - d_rd_q) : d_rd_q;
			flip_q <= v_q[VAL_W-1] ^ d_rd_q[VAL_W-1] ^ sub;
			acc_q  <= '0;
		end
		if (cmd.mul) begin
			if (cmd.mul_cnt != MUL_LAST) begin
				part_s1 <= mul_a * mul_b;
				sh_s1   <= cmd.mul_cnt[1:0];
			end
			if (cmd.mul_cnt != 3'd0)
				acc_q <= acc_q + part_sh;
		end
	end

	assign prod_ext = SC_W'(acc_q);

	always_comb begin
		case (sel_w)
			4'd2:    sc_d = prod_ext << 1;
			4'd3:    sc_d = prod_ext + (prod_ext << 1);
			4'd4:    sc_d = prod_ext << 2;
			4'd6:    sc_d = (prod_ext << 1) + (prod_ext << 2);
			4'd8:    sc_d = prod_ext << 3;
			default: sc_d = prod_ext;
		endcase
	end

	assign rnd_sum = sc_q + RND;
	assign rt_add  = flip_q ? ~rt_q : rt_q;
	assign g_sum   = g_rd_q + rt_add + VAL_W'(flip_q);

	always_ff @(posedge clk) begin
		if (cmd.scale)
			sc_q <= sc_d;
		if (cmd.round)
			rt_q <= rnd_sum[RSH +: VAL_W];
	end

	// reset clearing sweep of the G store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.init_wr && clr_q != CLR_END)
			clr_q <= clr_q + 1'b1;
	end

	assign d_we = cmd.exec && idx_ok && (op_q == OP_LOAD);
	assign g_we = cmd.init_wr || cmd.wr || (cmd.exec && idx_ok && (op_q == OP_CLEAR));
	assign g_wa = cmd.init_wr ? clr_q : (cmd.wr ? ga : pq_addr);
	assign g_wd = cmd.wr ? g_sum : '0;
	assign g_re = cmd.round || (cmd.exec && idx_ok && (op_q == OP_READ));
	assign g_ra = cmd.round ? ga : pq_addr;

	always_ff @(posedge clk) begin
		if (g_we)
			g_mem[g_wa] <= g_wd;
		if (g_re)
			g_rd_q <= g_mem[g_ra];
	end

	always_ff @(posedge clk) begin
		if (d_we)
			d_mem[pq_addr] <= v_q;
		if (cmd.d_rd)
			d_rd_q <= d_mem[da];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_data_q <= idx_ok ? g_rd_q : '0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign st.op       = op_q;
	assign st.idx_ok   = idx_ok;
	assign st.v_zero   = (v_q == '0);
	assign st.npairs   = npairs_q;
	assign st.clr_last = (clr_q == CLR_END);
	assign st.out_busy = out_valid_q && !out_ready;

endmodule

>>> rtl/fock_integral_digest.sv
// Two-electron G build: density and G matrices held as packed lower triangles
// in on-chip RAM, signed fixed point with FRACTION_BITS fraction bits. One item
// at a time. After reset the G store is swept to zero, one entry per cycle,
// with s_tready low. A read can wait on m_tready. A digest does 2, 4 or 6
// accumulations: each one is a density RAM read, a 64x64 magnitude product
// built from four 32x32 partials on one multiplier, scaling and rounding,
// then a read-modify-write of the G RAM. Zero integrals and out-of-range
// indices end a digest after the execute state.
module fock_integral_digest import fid_pkg::*; #(
	parameter int BASIS_FUNCTIONS = 128,
	parameter int FRACTION_BITS   = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// index_p, index_q, index_r, index_s, value, zero pad
	input  logic [TDATA_W-1:0] s_tdata,
	// opcode
	input  logic [TUSER_W-1:0] s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// g_value
	output logic [VAL_W-1:0]   m_tdata
);

	cmd_t    cmd;
	status_t st;

	fid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	fid_dp #(
		.BASIS_FUNCTIONS (BASIS_FUNCTIONS),
		.FRACTION_BITS   (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata[IN_W-1:0]),
		.in_op     (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> rtl/fid_checker.sv
module fid_checker import fid_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [VAL_W-1:0] m_tdata
);

	// one item at a time: no back-to-back input transfers
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// a fresh result only appears as an item completes
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a pending read");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind fock_integral_digest fid_checker u_fid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/sv/tb_fock_integral_digest.sv
`timescale 1ns / 1ps

module tb_fock_integral_digest;
	import fid_pkg::*;

	localparam int NBF        = 128;
	localparam int TRI_DEPTH  = NBF * (NBF + 1) / 2;
	localparam int RND_SHIFT  = 40 + 3;
	localparam int CYCLE_CAP  = 1000000;
	localparam int DRAIN_CYC  = 80;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic [TUSER_W-1:0] s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [VAL_W-1:0]   m_tdata;

	fock_integral_digest dut (.*);

	// predictor state
	logic [63:0] g_mirror [TRI_DEPTH];
	logic [63:0] dens_mirror [TRI_DEPTH];
	bit          dens_loaded [TRI_DEPTH];
	logic [63:0] g_expected [$];

	int errors, cycles, n_sent, n_digests, n_reads_ok;
	int idle_pct, stall_pct;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// result checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (g_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected G transfer, actual %h", $time, m_tdata);
			end else begin
				if (m_tdata !== g_expected[0]) begin
					errors++;
					$display("%0t: g_value mismatch, expected %h actual %h",
						$time, g_expected[0], m_tdata);
				end else
					n_reads_ok++;
				void'(g_expected.pop_front());
			end
		end
	end

	function automatic int tri_idx(int a, int b);
		int hi, lo;
		hi = a > b ? a : b;
		lo = a > b ? b : a;
		return hi * (hi + 1) / 2 + lo;
	endfunction

	// w/8 * a * b, rounded half away from zero, wrapped to 64 bits
	function automatic logic [63:0] weighted_term(logic [63:0] a, logic [63:0] b, int w);
		logic        neg;
		logic [63:0] ma, mb, r;
		logic [130:0] full;
		neg  = a[63] ^ b[63];
		ma   = a[63] ? 64'd0 - a : a;
		mb   = b[63] ? 64'd0 - b : b;
		full = 131'(ma) * 131'(mb) * 131'(w) + (131'(1) << (RND_SHIFT - 1));
		r    = full[RND_SHIFT +: 64];
		return neg ? 64'd0 - r : r;
	endfunction

	task automatic accumulate_pair(int a, int b, int c, int d, logic [63:0] v, int w,
			bit sub);
		int ab, cd;
		logic [63:0] t1, t2;
		ab = tri_idx(a, b);
		cd = tri_idx(c, d);
		t1 = weighted_term(v, dens_mirror[cd], w);
		t2 = weighted_term(v, dens_mirror[ab], w);
		if (sub) begin
			g_mirror[ab] = g_mirror[ab] - t1;
			g_mirror[cd] = g_mirror[cd] - t2;
		end else begin
			g_mirror[ab] = g_mirror[ab] + t1;
			g_mirror[cd] = g_mirror[cd] + t2;
		end
	endtask

	task automatic predict_digest(int p, int q, int r, int s, logic [63:0] v);
		int i, j, k, l, t, wx;
		bit half;
		if (v == 64'd0)
			return;
		if (p < q) begin t = p; p = q; q = t; end
		if (r < s) begin t = r; r = s; s = t; end
		if (tri_idx(p, q) >= tri_idx(r, s)) begin
			i = p; j = q; k = r; l = s;
		end else begin
			i = r; j = s; k = p; l = q;
		end
		half = tri_idx(i, j) == tri_idx(k, l);
		if (j == k) begin
			if (i == j || k == l)
				accumulate_pair(i, j, k, l, v, half ? 2 : 4, 1'b0);
			else begin
				accumulate_pair(i, j, k, l, v, half ? 3 : 6, 1'b0);
				accumulate_pair(i, l, k, j, v, tri_idx(i, l) == tri_idx(k, j) ? 2 : 4, 1'b1);
			end
		end else if (i == k || j == l) begin
			accumulate_pair(i, j, k, l, v, half ? 3 : 6, 1'b0);
			accumulate_pair(i, k, j, l, v, tri_idx(i, k) == tri_idx(j, l) ? 2 : 4, 1'b1);
		end else begin
			wx = tri_idx(i, k) == tri_idx(j, l) ? 1 : 2;
			accumulate_pair(i, j, k, l, v, half ? 4 : 8, 1'b0);
			accumulate_pair(i, k, j, l, v, wx, 1'b1);
			if (i != j && k != l)
				accumulate_pair(i, l, k, j, v, wx, 1'b1);
		end
	endtask

	// one transfer on the input side; called and returns at a falling edge
	task automatic send_item(op_t op, int p, int q, int r, int s, logic [63:0] v);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'd0, v, 7'(s), 7'(r), 7'(q), 7'(p)};
		do @(posedge clk); while (!s_tready);
		n_sent++;
		case (op)
			OP_LOAD: begin
				dens_mirror[tri_idx(p, q)] = v;
				dens_loaded[tri_idx(p, q)] = 1'b1;
			end
			OP_DIGEST: begin
				n_digests++;
				predict_digest(p, q, r, s, v);
			end
			OP_READ:  g_expected.push_back(g_mirror[tri_idx(p, q)]);
			OP_CLEAR: g_mirror[tri_idx(p, q)] = 64'd0;
		endcase
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(5))
			0: return {$urandom, $urandom};
			1: return 64'(signed'($urandom_range(2000)) - 1000) << $urandom_range(44);
			2: return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
			default: return 64'({{32{1'b0}}, $urandom} << 12) ^ ({64{$urandom_range(1)}});
		endcase
	endfunction

	function automatic int rand_index();
		return $urandom_range(99) < 80 ? $urandom_range(7) : $urandom_range(NBF - 1);
	endfunction

	// loads every density entry a digest over these indices might touch
	task automatic digest_with_density(int p, int q, int r, int s, logic [63:0] v);
		int ix [4];
		ix = '{p, q, r, s};
		foreach (ix[a])
			for (int b = a + 1; b < 4; b++)
				if (!dens_loaded[tri_idx(ix[a], ix[b])])
					send_item(OP_LOAD, ix[a], ix[b], 0, 0, rand_value());
		for (int a = 0; a < 4; a++)
			if (!dens_loaded[tri_idx(ix[a], ix[a])])
				send_item(OP_LOAD, ix[a], ix[a], 0, 0, rand_value());
		send_item(OP_DIGEST, p, q, r, s, v);
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (g_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_item(OP_LOAD, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(OP_LOAD, 1, 0, 0, 0, 64'h8000_0000_0000_0000);
		send_item(OP_LOAD, 1, 1, 0, 0, 64'h0000_0100_0000_0000);
		send_item(OP_LOAD, 127, 127, 0, 0, 64'hFFFF_FF00_0000_0000);
		digest_with_density(0, 0, 0, 0, 64'h0000_0100_0000_0000);   // all equal
		digest_with_density(1, 0, 1, 0, 64'h7FFF_FFFF_FFFF_FFFF);   // ij equals kl
		digest_with_density(1, 1, 0, 0, 64'h8000_0000_0000_0000);   // i==j, k==l
		digest_with_density(0, 1, 2, 1, 64'hFFFF_FF80_0000_0000);   // j==k after sort
		digest_with_density(2, 1, 2, 0, 64'h0000_0080_0000_0001);   // i==k
		digest_with_density(2, 0, 1, 0, 64'h0000_0000_0000_0001);   // j==l
		digest_with_density(3, 2, 1, 0, 64'h0000_0123_4567_89AB);   // general
		digest_with_density(1, 0, 3, 2, 64'hFFFF_FEDC_BA98_7654);   // pairs swapped
		digest_with_density(127, 0, 126, 1, 64'h0000_0200_0000_0000);
		digest_with_density(127, 127, 127, 127, 64'h0000_0100_0000_0000);
		digest_with_density(3, 2, 1, 0, 64'd0);                     // zero integral
		send_item(OP_READ, 0, 0, 0, 0, 64'd0);
		send_item(OP_READ, 0, 1, 0, 0, 64'd0);
		send_item(OP_READ, 127, 127, 0, 0, 64'd0);
		send_item(OP_READ, 3, 2, 0, 0, 64'd0);
		send_item(OP_CLEAR, 0, 0, 0, 0, 64'd0);
		send_item(OP_READ, 0, 0, 0, 0, 64'd0);
		send_item(OP_READ, 126, 5, 0, 0, 64'd0);
		wait_results();
	endtask

	// sends roughly count input transfers, density loads included
	task automatic test_random(int idle, int stall, int count);
		int sel;
		int stop;
		idle_pct  = idle;
		stall_pct = stall;
		stop      = n_sent + count;
		while (n_sent < stop) begin
			sel = $urandom_range(99);
			if (sel < 45)
				digest_with_density(rand_index(), rand_index(), rand_index(), rand_index(),
					$urandom_range(19) == 0 ? 64'd0 : rand_value());
			else if (sel < 65)
				send_item(OP_LOAD, rand_index(), rand_index(), $urandom_range(127),
					$urandom_range(127), rand_value());
			else if (sel < 90)
				send_item(OP_READ, rand_index(), rand_index(), $urandom_range(127),
					$urandom_range(127), {$urandom, $urandom});
			else
				send_item(OP_CLEAR, rand_index(), rand_index(), $urandom_range(127),
					$urandom_range(127), {$urandom, $urandom});
		end
		// hold off until every read has come back
		wait_results();
	endtask

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		for (int n = 0; n < TRI_DEPTH; n++) begin
			g_mirror[n]    = 64'd0;
			dens_mirror[n] = 64'd0;
			dens_loaded[n] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(0, 0, 300);
		test_random(56, 0, 300);
		test_random(0, 56, 300);
		test_random(9, 9, 300);

		s_tvalid <= 1'b0;
		while (g_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Covered %0d transfers in, %0d digests, %0d G reads checked,", n_sent,
			n_digests, n_reads_ok);
		$display("over four idle and stall mixes; %0d mismatches.", errors);
		if (errors == 0 && g_expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
